@@ hdl/fcnp_pkg.sv @@
// fcnp_pkg: shared types and constants for the framed number parser
// no dependencies; imported by every module of the block
`default_nettype none

package fcnp_pkg;

    // defaults for the top-level parameters
    localparam int MAX_FIELD_CHARS_DEF = 16;
    localparam int MAX_FIELDS_DEF      = 16;

    // fixed-point format and fraction parsing
    localparam int FRAC_BITS       = 16;
    localparam int MAX_FRAC_DIGITS = 6;
    localparam int POW10_MAX       = 10 ** MAX_FRAC_DIGITS;
    localparam int FRAC_ACC_W      = $clog2(POW10_MAX);

    // result field widths
    localparam int INT_W = 33;
    localparam int FIX_W = 49;

    // field kind codes
    localparam logic [1:0] KIND_UNSIGNED = 2'd0;
    localparam logic [1:0] KIND_SIGNED   = 2'd1;
    localparam logic [1:0] KIND_FIXED    = 2'd2;

    typedef struct packed {
        logic [7:0] start_char;
        logic [7:0] end_char;
        logic [7:0] separator_char;
    } cfg_t;

    // one result on its way from the parser through the fixed-point conversion
    typedef struct packed {
        logic                  is_frame_end;
        logic [1:0]            kind;
        logic [3:0]            kind_index;
        logic [INT_W-1:0]      int_value;
        logic                  too_long;
        logic                  neg;
        logic [31:0]           int_part;
        logic [FRAC_ACC_W-1:0] frac;
        logic [2:0]            fdig;
    } field_rec_t;

endpackage

`default_nettype wire

@@ hdl/fcnp_field_parser.sv @@
// fcnp_field_parser: per-byte frame and field parser with a result register
// depends on fcnp_pkg
`default_nettype none

module fcnp_field_parser #(
    parameter int MAX_FIELD_CHARS = fcnp_pkg::MAX_FIELD_CHARS_DEF,
    parameter int MAX_FIELDS      = fcnp_pkg::MAX_FIELDS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  fcnp_pkg::cfg_t      cfg,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_rx_byte,
    output logic                rec_valid,
    output fcnp_pkg::field_rec_t rec,
    input  logic                rec_ready
);
    import fcnp_pkg::*;

    localparam int CCW   = $clog2(MAX_FIELD_CHARS + 1);
    localparam int LIMIT = (MAX_FIELDS > 16) ? 16 : MAX_FIELDS;
    localparam int KCW   = $clog2(LIMIT + 1);

    localparam logic [1:0] LEAD_NONE  = 2'd0;
    localparam logic [1:0] LEAD_MINUS = 2'd1;
    localparam logic [1:0] LEAD_PLUS  = 2'd2;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef struct packed {
        logic [CCW-1:0]        char_count;
        logic [1:0]            lead_sign;
        logic                  saw_minus;
        logic                  saw_point;
        logic [31:0]           int_accum;
        logic                  int_stopped;
        logic                  frac_open;
        logic [FRAC_ACC_W-1:0] frac_accum;
        logic [2:0]            frac_digits;
        logic                  frac_stopped;
        logic                  too_long;
    } fld_state_t;

    logic            in_frame_reg, in_frame_next;
    logic            null_seen_reg, null_seen_next;
    fld_state_t      fld_reg, fld_next, fld_took;
    logic [KCW-1:0]  kc_reg [3];
    logic [KCW-1:0]  kc_next [3];
    logic            rec_valid_reg, rec_valid_next;
    field_rec_t      rec_reg, rec_next, field_rec;

    logic            take;
    logic            digit;
    logic [3:0]      dval;
    logic [1:0]      cur_kind;
    logic [KCW-1:0]  cur_count;
    logic            room;
    logic [31:0]     signed_v;

    assign s_ready   = !rec_valid_reg || rec_ready;
    assign take      = s_valid && s_ready;
    assign rec_valid = rec_valid_reg;
    assign rec       = rec_reg;

    assign digit = s_rx_byte inside {[CH_ZERO:CH_NINE]};
    assign dval  = s_rx_byte[3:0];

    // one character into the current field
    always_comb begin
        fld_took = fld_reg;
        if (s_rx_byte == CH_MINUS) begin
            fld_took.saw_minus = 1'b1;
        end
        if (s_rx_byte == CH_POINT) begin
            fld_took.saw_point = 1'b1;
        end
        if (fld_reg.frac_open) begin
            if (!fld_reg.frac_stopped) begin
                if (digit && (fld_reg.frac_digits < 3'(MAX_FRAC_DIGITS))) begin
                    fld_took.frac_accum = FRAC_ACC_W'({fld_reg.frac_accum, 3'b000})
                                        + FRAC_ACC_W'({fld_reg.frac_accum, 1'b0})
                                        + FRAC_ACC_W'(dval);
                    fld_took.frac_digits = fld_reg.frac_digits + 3'd1;
                end else begin
                    fld_took.frac_stopped = 1'b1;
                end
            end
        end else if (!fld_reg.int_stopped) begin
            if ((fld_reg.char_count == '0) &&
                ((s_rx_byte == CH_MINUS) || (s_rx_byte == CH_PLUS))) begin
                fld_took.lead_sign = (s_rx_byte == CH_MINUS) ? LEAD_MINUS : LEAD_PLUS;
            end else if (digit) begin
                // accum * 10 + digit, wrapping at 32 bits
                fld_took.int_accum = 32'({fld_reg.int_accum, 3'b000})
                                   + 32'({fld_reg.int_accum, 1'b0})
                                   + 32'(dval);
            end else begin
                fld_took.int_stopped = 1'b1;
                if (s_rx_byte == CH_POINT) begin
                    fld_took.frac_open = 1'b1;
                end
            end
        end
        fld_took.char_count = CCW'(fld_reg.char_count + 1'b1);
    end

    // result for the field that a separator closes
    always_comb begin
        if (fld_reg.saw_point) begin
            cur_kind = KIND_FIXED;
        end else if (fld_reg.saw_minus) begin
            cur_kind = KIND_SIGNED;
        end else begin
            cur_kind = KIND_UNSIGNED;
        end

        case (cur_kind)
            KIND_UNSIGNED: begin
                cur_count = kc_reg[0];
            end
            KIND_SIGNED: begin
                cur_count = kc_reg[1];
            end
            KIND_FIXED: begin
                cur_count = kc_reg[2];
            end
            default: begin
                cur_count = '0;
            end
        endcase
        room = cur_count < KCW'(LIMIT);

        signed_v = (fld_reg.lead_sign == LEAD_MINUS) ? (32'd0 - fld_reg.int_accum)
                                                      : fld_reg.int_accum;

        field_rec              = '0;
        field_rec.kind         = cur_kind;
        field_rec.kind_index   = 4'(cur_count);
        field_rec.too_long     = fld_reg.too_long;
        case (cur_kind)
            KIND_UNSIGNED: begin
                // a leading sign gives an unsigned field a value of zero
                if (fld_reg.lead_sign == LEAD_NONE) begin
                    field_rec.int_value = {1'b0, fld_reg.int_accum};
                end
            end
            KIND_SIGNED: begin
                field_rec.int_value = {signed_v[31], signed_v};
            end
            KIND_FIXED: begin
                field_rec.neg      = fld_reg.lead_sign == LEAD_MINUS;
                field_rec.int_part = fld_reg.int_accum;
                field_rec.frac     = fld_reg.frac_accum;
                field_rec.fdig     = fld_reg.frac_digits;
            end
            default: begin
                field_rec.kind = KIND_UNSIGNED;
            end
        endcase
    end

    always_comb begin
        fld_next       = fld_reg;
        in_frame_next  = in_frame_reg;
        null_seen_next = null_seen_reg;
        kc_next        = kc_reg;
        rec_next       = rec_reg;
        rec_valid_next = rec_valid_reg && !rec_ready;
        if (take) begin
            if (!in_frame_reg) begin
                if (s_rx_byte == cfg.start_char) begin
                    in_frame_next  = 1'b1;
                    null_seen_next = 1'b0;
                    kc_next        = '{default: '0};
                    fld_next       = '0;
                end
            end else if (s_rx_byte == cfg.end_char) begin
                // an unterminated field is dropped here
                in_frame_next         = 1'b0;
                fld_next              = '0;
                rec_next              = '0;
                rec_next.is_frame_end = 1'b1;
                rec_valid_next        = 1'b1;
            end else if (!null_seen_reg) begin
                if (s_rx_byte == CH_NUL) begin
                    null_seen_next = 1'b1;
                    fld_next       = '0;
                end else if (s_rx_byte == cfg.separator_char) begin
                    fld_next = '0;
                    if (room) begin
                        rec_next       = field_rec;
                        rec_valid_next = 1'b1;
                        case (cur_kind)
                            KIND_UNSIGNED: begin
                                kc_next[0] = KCW'(cur_count + 1'b1);
                            end
                            KIND_SIGNED: begin
                                kc_next[1] = KCW'(cur_count + 1'b1);
                            end
                            KIND_FIXED: begin
                                kc_next[2] = KCW'(cur_count + 1'b1);
                            end
                            default: begin
                                kc_next = kc_reg;
                            end
                        endcase
                    end
                end else if (fld_reg.char_count < CCW'(MAX_FIELD_CHARS)) begin
                    fld_next = fld_took;
                end else begin
                    fld_next.too_long = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg  <= 1'b0;
            null_seen_reg <= 1'b0;
            fld_reg       <= '0;
            kc_reg        <= '{default: '0};
            rec_valid_reg <= 1'b0;
        end else begin
            in_frame_reg  <= in_frame_next;
            null_seen_reg <= null_seen_next;
            fld_reg       <= fld_next;
            kc_reg        <= kc_next;
            rec_valid_reg <= rec_valid_next;
        end
        rec_reg <= rec_next;
    end

`ifndef SYNTHESIS
    // outside a frame the field state is always clear
    a_idle_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_frame_reg |-> (fld_reg.char_count == '0) && !fld_reg.too_long)
        else $error("field state not clear while idle");

    a_unsigned_range: assert property (@(posedge aclk) disable iff (!aresetn)
        rec_valid_reg && !rec_reg.is_frame_end && (rec_reg.kind == KIND_UNSIGNED)
        |-> !rec_reg.int_value[INT_W-1])
        else $error("unsigned field with sign bit set");

    a_count_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (kc_reg[0] <= KCW'(LIMIT)) && (kc_reg[1] <= KCW'(LIMIT)) && (kc_reg[2] <= KCW'(LIMIT)))
        else $error("per-kind field count beyond limit");
`endif

endmodule

`default_nettype wire

@@ hdl/fcnp_fixed_conv.sv @@
// fcnp_fixed_conv: pipelined fraction rounding, fixed-point assembly and output register
// depends on fcnp_pkg; takes records from fcnp_field_parser
`default_nettype none

module fcnp_fixed_conv (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  fcnp_pkg::field_rec_t                in_rec,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_is_frame_end,
    output logic [1:0]                          m_field_kind,
    output logic [3:0]                          m_kind_index,
    output logic signed [fcnp_pkg::INT_W-1:0]   m_int_value,
    output logic signed [fcnp_pkg::FIX_W-1:0]   m_fixed_value,
    output logic                                m_field_too_long
);
    import fcnp_pkg::*;

    // frac * 2^FRAC_BITS / 10^d is estimated as frac * floor(2^(FRAC_BITS+S) / 10^d) >> S,
    // which lands on the rounded quotient or one below; a back-multiply picks the right one
    localparam int RECIP_S = FRAC_ACC_W;
    localparam int PRODW   = FRAC_BITS + RECIP_S;
    localparam int RECIP_W = PRODW - 3;
    localparam int QW      = FRAC_BITS + 1;
    localparam int PW      = QW + FRAC_ACC_W;
    localparam int MAGW    = 33 + FRAC_BITS;
    localparam int SATW    = (MAGW > FIX_W) ? MAGW : FIX_W;

    localparam longint unsigned SCALE       = 64'd1 << PRODW;
    localparam longint unsigned RND_HALF    = 64'd1 << (RECIP_S - 1);
    localparam longint unsigned FIX_MIN_MAG = 64'd1 << (FIX_W - 1);
    localparam longint unsigned FIX_MAX     = FIX_MIN_MAG - 64'd1;

    typedef logic [RECIP_W-1:0]    recip_t;
    typedef logic [FRAC_ACC_W-1:0] den_t;

    // indexed by fraction digit count; the last code is unused
    localparam recip_t RECIP_TAB [8] = '{
        recip_t'(0),
        recip_t'(SCALE / 10),
        recip_t'(SCALE / 100),
        recip_t'(SCALE / 1000),
        recip_t'(SCALE / 10000),
        recip_t'(SCALE / 100000),
        recip_t'(SCALE / 1000000),
        recip_t'(0)
    };
    localparam den_t DEN_TAB [8] = '{
        den_t'(1), den_t'(10), den_t'(100), den_t'(1000),
        den_t'(10000), den_t'(100000), den_t'(1000000), den_t'(1)
    };

    logic              b_ready, c_ready, d_ready, e_ready, out_ready;

    logic              b_valid_reg;
    field_rec_t        b_rec_reg;
    logic [PRODW-1:0]  b_prod_reg, prod_next;

    logic              c_valid_reg;
    field_rec_t        c_rec_reg;
    logic [QW-1:0]     c_qest_reg, c_qp1_reg, qest_next, qp1_next;
    logic [PRODW:0]    rnd;

    logic              d_valid_reg;
    field_rec_t        d_rec_reg;
    logic [QW-1:0]     d_q_reg, q_next;
    logic [PW-1:0]     back_prod, nval;

    logic              e_valid_reg;
    field_rec_t        e_rec_reg;
    logic [MAGW-1:0]   e_mag_reg, mag_next;

    logic [SATW-1:0]   mag_ext;
    logic [FIX_W-1:0]  fix_sat;

    logic              m_valid_reg;
    logic              m_is_frame_end_reg;
    logic [1:0]        m_field_kind_reg;
    logic [3:0]        m_kind_index_reg;
    logic [INT_W-1:0]  m_int_value_reg;
    logic [FIX_W-1:0]  m_fixed_value_reg;
    logic              m_field_too_long_reg;

    assign out_ready = !m_valid_reg || m_ready;
    assign e_ready   = !e_valid_reg || out_ready;
    assign d_ready   = !d_valid_reg || e_ready;
    assign c_ready   = !c_valid_reg || d_ready;
    assign b_ready   = !b_valid_reg || c_ready;
    assign in_ready  = b_ready;

    // reciprocal multiply
    assign prod_next = PRODW'(in_rec.frac) * PRODW'(RECIP_TAB[in_rec.fdig]);

    // round to nearest, half up
    assign rnd       = {1'b0, b_prod_reg} + (PRODW + 1)'(RND_HALF);
    assign qest_next = rnd[PRODW:RECIP_S];
    assign qp1_next  = QW'(qest_next + 1'b1);

    // take the higher candidate if it still fits under frac * 2^FRAC_BITS + 10^d / 2
    assign back_prod = PW'(c_qp1_reg) * PW'(DEN_TAB[c_rec_reg.fdig]);
    assign nval      = PW'({c_rec_reg.frac, {FRAC_BITS{1'b0}}})
                     + PW'(DEN_TAB[c_rec_reg.fdig] >> 1);
    assign q_next    = (back_prod <= nval) ? c_qp1_reg : c_qest_reg;

    assign mag_next  = (MAGW'(d_rec_reg.int_part) << FRAC_BITS) + MAGW'(d_q_reg);

    // apply the sign and saturate to the 49-bit range
    always_comb begin
        mag_ext = SATW'(e_mag_reg);
        if (e_rec_reg.neg) begin
            if (mag_ext >= SATW'(FIX_MIN_MAG)) begin
                fix_sat = FIX_W'(FIX_MIN_MAG);
            end else begin
                fix_sat = FIX_W'(0) - FIX_W'(mag_ext);
            end
        end else begin
            if (mag_ext > SATW'(FIX_MAX)) begin
                fix_sat = FIX_W'(FIX_MAX);
            end else begin
                fix_sat = FIX_W'(mag_ext);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (b_ready) begin
                b_valid_reg <= in_valid;
            end
            if (c_ready) begin
                c_valid_reg <= b_valid_reg;
            end
            if (d_ready) begin
                d_valid_reg <= c_valid_reg;
            end
            if (e_ready) begin
                e_valid_reg <= d_valid_reg;
            end
            if (out_ready) begin
                m_valid_reg <= e_valid_reg;
            end
        end
        if (b_ready) begin
            b_rec_reg  <= in_rec;
            b_prod_reg <= prod_next;
        end
        if (c_ready) begin
            c_rec_reg  <= b_rec_reg;
            c_qest_reg <= qest_next;
            c_qp1_reg  <= qp1_next;
        end
        if (d_ready) begin
            d_rec_reg <= c_rec_reg;
            d_q_reg   <= q_next;
        end
        if (e_ready) begin
            e_rec_reg <= d_rec_reg;
            e_mag_reg <= mag_next;
        end
        if (out_ready) begin
            m_is_frame_end_reg   <= e_rec_reg.is_frame_end;
            m_field_kind_reg     <= e_rec_reg.kind;
            m_kind_index_reg     <= e_rec_reg.kind_index;
            m_int_value_reg      <= e_rec_reg.int_value;
            m_field_too_long_reg <= e_rec_reg.too_long;
            if (!e_rec_reg.is_frame_end && (e_rec_reg.kind == KIND_FIXED)) begin
                m_fixed_value_reg <= fix_sat;
            end else begin
                m_fixed_value_reg <= '0;
            end
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_is_frame_end   = m_is_frame_end_reg;
    assign m_field_kind     = m_field_kind_reg;
    assign m_kind_index     = m_kind_index_reg;
    assign m_int_value      = m_int_value_reg;
    assign m_fixed_value    = m_fixed_value_reg;
    assign m_field_too_long = m_field_too_long_reg;

`ifndef SYNTHESIS
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        b_valid_reg && !c_ready |=> b_valid_reg && $stable(b_prod_reg))
        else $error("first conversion stage lost data under stall");

    a_quot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        d_valid_reg && (d_rec_reg.kind == KIND_FIXED) |-> d_q_reg <= QW'(1 << FRAC_BITS))
        else $error("rounded fraction out of range");

    a_end_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_is_frame_end_reg
        |-> (m_field_kind_reg == KIND_UNSIGNED) && (m_int_value_reg == '0)
            && (m_fixed_value_reg == '0) && !m_field_too_long_reg)
        else $error("frame-end beat carries field data");

    a_fixed_only: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (m_field_kind_reg != KIND_FIXED) |-> m_fixed_value_reg == '0)
        else $error("fixed value set on integer beat");
`endif

endmodule

`default_nettype wire

@@ hdl/framed_csv_number_parser_core.sv @@
// Framed ASCII number parser, top level. Takes one received byte per beat on s_ and gives one
// beat on m_ per separated field up to the per-kind limit and one per frame end. A byte is
// taken every cycle while the result path has room; the field state (digit accumulators, kind
// flags, per-kind counts) is updated once per byte in a single register stage, which sets that
// rate. A result passes one parse stage, then the stages that round the fraction with a
// reciprocal multiply and a back-multiply check, add in the integer part and saturate, before
// it leaves the output register. Configuration registers are written through cfg_we/cfg_index/
// cfg_wdata; the user must write them only while no frame is in progress (not enforced).
// depends on fcnp_pkg, fcnp_field_parser, fcnp_fixed_conv
`default_nettype none

module framed_csv_number_parser_core #(
    parameter int MAX_FIELD_CHARS = fcnp_pkg::MAX_FIELD_CHARS_DEF,
    parameter int MAX_FIELDS      = fcnp_pkg::MAX_FIELDS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [1:0]                          cfg_index,
    input  logic [7:0]                          cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [7:0]                          s_rx_byte,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_is_frame_end,
    output logic [1:0]                          m_field_kind,
    output logic [3:0]                          m_kind_index,
    output logic signed [fcnp_pkg::INT_W-1:0]   m_int_value,
    output logic signed [fcnp_pkg::FIX_W-1:0]   m_fixed_value,
    output logic                                m_field_too_long
);
    import fcnp_pkg::*;

    localparam logic [1:0] REG_START = 2'd0;
    localparam logic [1:0] REG_END   = 2'd1;
    localparam logic [1:0] REG_SEP   = 2'd2;

    localparam logic [7:0] START_RST = 8'h40;
    localparam logic [7:0] END_RST   = 8'h23;
    localparam logic [7:0] SEP_RST   = 8'h2C;

    cfg_t       cfg_reg;
    logic       rec_valid;
    logic       rec_ready;
    field_rec_t rec;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_char     <= START_RST;
            cfg_reg.end_char       <= END_RST;
            cfg_reg.separator_char <= SEP_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_START: begin
                    cfg_reg.start_char <= cfg_wdata;
                end
                REG_END: begin
                    cfg_reg.end_char <= cfg_wdata;
                end
                REG_SEP: begin
                    cfg_reg.separator_char <= cfg_wdata;
                end
                default: begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    fcnp_field_parser #(
        .MAX_FIELD_CHARS (MAX_FIELD_CHARS),
        .MAX_FIELDS      (MAX_FIELDS)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_byte (s_rx_byte),
        .rec_valid (rec_valid),
        .rec       (rec),
        .rec_ready (rec_ready)
    );

    fcnp_fixed_conv u_conv (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .in_valid         (rec_valid),
        .in_ready         (rec_ready),
        .in_rec           (rec),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_is_frame_end   (m_is_frame_end),
        .m_field_kind     (m_field_kind),
        .m_kind_index     (m_kind_index),
        .m_int_value      (m_int_value),
        .m_fixed_value    (m_fixed_value),
        .m_field_too_long (m_field_too_long)
    );

endmodule

`default_nettype wire
